@@ src/sops_pkg.sv @@
// ----------------------------------------------------------------------------
// sops_pkg
// shared widths, request codes, datapath operation codes and the
// command / status structs between the sieve controller and datapath
// ----------------------------------------------------------------------------
package sops_pkg;

  // bitmap geometry
  localparam int SEG_BITS = 4096;
  localparam int IDX_W    = $clog2(SEG_BITS);
  localparam int POS_W    = IDX_W + 1;

  // request / result field widths
  localparam int TYPE_W   = 2;
  localparam int SEG_W    = 19;
  localparam int PRIME_W  = 32;
  localparam int VALUE_W  = 32;

  // derived arithmetic widths
  localparam int BASE_W   = SEG_W + IDX_W;
  localparam int NUM_W    = BASE_W + 1;
  localparam int WRK_W    = ((NUM_W > PRIME_W) ? NUM_W : PRIME_W) + 2;
  localparam int SQ_W     = 2 * PRIME_W;
  localparam int DIV_CW   = $clog2(NUM_W);

  // request types
  localparam logic [TYPE_W-1:0] REQ_OPEN   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_STRIKE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FETCH  = 2'd2;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_CAPTURE   = 4'd1;
  localparam op_t OP_CLEAR     = 4'd2;
  localparam op_t OP_DIV_STEP  = 4'd3;
  localparam op_t OP_PREP_A    = 4'd4;
  localparam op_t OP_PREP_B    = 4'd5;
  localparam op_t OP_PREP_C    = 4'd6;
  localparam op_t OP_PREP_D    = 4'd7;
  localparam op_t OP_PREP_E    = 4'd8;
  localparam op_t OP_STRIKE    = 4'd9;
  localparam op_t OP_TWO       = 4'd10;
  localparam op_t OP_SCAN_INIT = 4'd11;
  localparam op_t OP_SCAN      = 4'd12;
  localparam op_t OP_LOAD      = 4'd13;

  typedef struct packed {
    op_t op;
  } sops_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              clear_last;
    logic              prime_bad;
    logic              need_two;
    logic              div_last;
    logic              sq_far;
    logic              strike_end;
    logic              scan_hit;
    logic              scan_exh;
  } sops_status_t;

endpackage

@@ src/sops_req_if.sv @@
// ----------------------------------------------------------------------------
// sops_req_if
// request channel of the sieve: valid / ready handshake and request payload
// ----------------------------------------------------------------------------
interface sops_req_if;
  import sops_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [SEG_W-1:0]   segment;
  logic [PRIME_W-1:0] prime;

  modport source (output valid, output req_type, output segment, output prime,
                  input ready);
  modport sink   (input valid, input req_type, input segment, input prime,
                  output ready);
endinterface

@@ src/sops_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sops_rsp_if
// result channel of the sieve: valid / ready handshake and result payload
// ----------------------------------------------------------------------------
interface sops_rsp_if;
  import sops_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               found;

  modport source (output valid, output value, output found, input ready);
  modport sink   (input valid, input value, input found, output ready);
endinterface

@@ src/sops_ram.sv @@
// ----------------------------------------------------------------------------
// sops_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sops_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sops_datapath.sv @@
// ----------------------------------------------------------------------------
// sops_datapath
// segment state, bitmap ram, remainder divider, cross-out address walk,
// bitmap scan and result registers; driven one operation per cycle
// ----------------------------------------------------------------------------
module sops_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sops_pkg::sops_cmd_t             cmd,
  output sops_pkg::sops_status_t          status,
  input  logic [sops_pkg::TYPE_W-1:0]     req_type,
  input  logic [sops_pkg::SEG_W-1:0]      segment,
  input  logic [sops_pkg::PRIME_W-1:0]    prime,
  output logic [sops_pkg::VALUE_W-1:0]    value,
  output logic                            found
);
  import sops_pkg::*;

  // segment state
  logic [TYPE_W-1:0]  req_type_q;
  logic [PRIME_W-1:0] prime_q;
  logic [BASE_W-1:0]  base;
  logic [POS_W-1:0]   scan_pos;
  logic               two_rep;
  logic [IDX_W-1:0]   clr_ctr;

  // remainder divider
  logic [PRIME_W-1:0] rem;
  logic [NUM_W-1:0]   dvd;
  logic [DIV_CW-1:0]  div_ctr;
  logic [PRIME_W:0]   rem_sh;
  logic [PRIME_W:0]   rem_diff;

  // cross-out setup and walk
  logic [SQ_W-1:0]    sq;
  logic [SQ_W-1:0]    sq_prod;
  logic [PRIME_W-1:0] tadd;
  logic               sq_far;
  logic [WRK_W-1:0]   m;
  logic [WRK_W-1:0]   ix;

  // scan
  logic [POS_W-1:0]   issue_ptr;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_data;
  logic [NUM_W-1:0]   hit_num;

  // results
  logic [VALUE_W-1:0] res_value;
  logic               res_found;

  // numbers of the open segment
  logic [NUM_W-1:0]   lo;
  logic [NUM_W-1:0]   hi;

  // ram ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_wdata;

  assign lo       = {base, 1'b1};
  assign hi       = {base + BASE_W'(SEG_BITS - 1), 1'b1};
  assign rem_sh   = {rem, dvd[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, prime_q};
  assign sq_prod  = prime_q * prime_q;
  assign hit_num  = {base + BASE_W'(rd_idx), 1'b1};

  assign ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_STRIKE);
  assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_ctr : ix[IDX_W-1:0];
  assign ram_wdata = (cmd.op == OP_STRIKE);

  sops_ram #(
    .WIDTH (1),
    .DEPTH (SEG_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_ptr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    status.req_type   = req_type_q;
    status.clear_last = &clr_ctr;
    status.prime_bad  = (prime_q < PRIME_W'(3)) || !prime_q[0];
    status.need_two   = (base == '0) && !two_rep;
    status.div_last   = (div_ctr == DIV_CW'(NUM_W - 1));
    status.sq_far     = sq_far;
    status.strike_end = (ix[WRK_W-1:IDX_W] != '0);
    status.scan_hit   = rd_pend && !rd_data;
    status.scan_exh   = !rd_pend && issue_ptr[IDX_W];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      scan_pos <= '0;
      two_rep  <= 1'b0;
      clr_ctr  <= '0;
      rd_pend  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          if (req_type == REQ_OPEN) begin
            base     <= {segment, IDX_W'(0)};
            scan_pos <= '0;
            two_rep  <= 1'b0;
            clr_ctr  <= '0;
          end
        end
        OP_CLEAR: begin
          clr_ctr <= clr_ctr + IDX_W'(1);
        end
        OP_TWO: begin
          two_rep <= 1'b1;
        end
        OP_SCAN_INIT: begin
          rd_pend <= 1'b0;
        end
        OP_SCAN: begin
          if (status.scan_hit) begin
            scan_pos <= POS_W'(rd_idx) + POS_W'(1);
            rd_pend  <= 1'b0;
          end else if (status.scan_exh) begin
            scan_pos <= POS_W'(SEG_BITS);
          end else begin
            rd_pend <= !issue_ptr[IDX_W];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        req_type_q <= req_type;
        prime_q    <= prime;
        res_value  <= '0;
        res_found  <= 1'b0;
        dvd        <= lo;
        rem        <= '0;
        div_ctr    <= '0;
      end
      OP_DIV_STEP: begin
        rem     <= rem_diff[PRIME_W] ? rem_sh[PRIME_W-1:0] : rem_diff[PRIME_W-1:0];
        dvd     <= {dvd[NUM_W-2:0], 1'b0};
        div_ctr <= div_ctr + DIV_CW'(1);
      end
      OP_PREP_A: begin
        sq   <= sq_prod;
        tadd <= (rem == '0) ? '0 : prime_q - rem;
      end
      OP_PREP_B: begin
        m      <= WRK_W'(lo) + WRK_W'(tadd);
        sq_far <= sq > SQ_W'(hi);
      end
      OP_PREP_C: begin
        if (!m[0]) begin
          m <= m + WRK_W'(prime_q);
        end
      end
      OP_PREP_D: begin
        if (SQ_W'(m) < sq) begin
          m <= WRK_W'(sq);
        end
      end
      OP_PREP_E: begin
        ix <= WRK_W'(m[WRK_W-1:1]) - WRK_W'(base);
      end
      OP_STRIKE: begin
        ix <= ix + WRK_W'(prime_q);
      end
      OP_TWO: begin
        res_value <= VALUE_W'(2);
        res_found <= 1'b1;
      end
      OP_SCAN_INIT: begin
        issue_ptr <= ((base == '0) && (scan_pos == '0)) ? POS_W'(1) : scan_pos;
      end
      OP_SCAN: begin
        if (status.scan_hit) begin
          res_value <= VALUE_W'(hit_num);
          res_found <= 1'b1;
        end else if (!status.scan_exh) begin
          rd_idx <= issue_ptr[IDX_W-1:0];
          if (!issue_ptr[IDX_W]) begin
            issue_ptr <= issue_ptr + POS_W'(1);
          end
        end
      end
      OP_LOAD: begin
        value <= res_value;
        found <= res_found;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/sops_ctrl.sv @@
// ----------------------------------------------------------------------------
// sops_ctrl
// sequencer of the sieve: request handshake, per-request operation sequence
// and the result register handshake
// ----------------------------------------------------------------------------
module sops_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sops_pkg::sops_status_t status,
  output sops_pkg::sops_cmd_t    cmd
);
  import sops_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_PREP_A   = 4'd4;
  localparam logic [3:0] S_PREP_B   = 4'd5;
  localparam logic [3:0] S_PREP_C   = 4'd6;
  localparam logic [3:0] S_PREP_D   = 4'd7;
  localparam logic [3:0] S_PREP_E   = 4'd8;
  localparam logic [3:0] S_STRIKE   = 4'd9;
  localparam logic [3:0] S_SCAN     = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       from_reset;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) begin
          state_next = from_reset ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.req_type)
          REQ_OPEN: begin
            state_next = S_CLEAR;
          end
          REQ_STRIKE: begin
            state_next = status.prime_bad ? S_DONE : S_DIV;
          end
          REQ_FETCH: begin
            if (status.need_two) begin
              cmd.op     = OP_TWO;
              state_next = S_DONE;
            end else begin
              cmd.op     = OP_SCAN_INIT;
              state_next = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_PREP_A;
        end
      end
      S_PREP_A: begin
        cmd.op     = OP_PREP_A;
        state_next = S_PREP_B;
      end
      S_PREP_B: begin
        cmd.op     = OP_PREP_B;
        state_next = S_PREP_C;
      end
      S_PREP_C: begin
        // square of the prime beyond the segment: nothing to cross out
        if (status.sq_far) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_PREP_C;
          state_next = S_PREP_D;
        end
      end
      S_PREP_D: begin
        cmd.op     = OP_PREP_D;
        state_next = S_PREP_E;
      end
      S_PREP_E: begin
        cmd.op     = OP_PREP_E;
        state_next = S_STRIKE;
      end
      S_STRIKE: begin
        if (status.strike_end) begin
          state_next = S_DONE;
        end else begin
          cmd.op = OP_STRIKE;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_hit || status.scan_exh) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op         = OP_LOAD;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      from_reset <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == S_CLEAR && status.clear_last) begin
        from_reset <= 1'b0;
      end
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISPATCH && !in_ready)
    else $error("accepted beat did not move to dispatch");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done step");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !(status.scan_hit && status.scan_exh))
    else $error("scan reports hit and exhaustion together");

  a_div_to_prep: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && status.div_last |=> state == S_PREP_A)
    else $error("divider finish did not start setup");

endmodule

@@ src/segmented_odd_prime_sieve.sv @@
// ----------------------------------------------------------------------------
// segmented_odd_prime_sieve
// segmented odd-only sieve of eratosthenes over a bitmap of odd numbers
// ----------------------------------------------------------------------------
// The block keeps one segment of SEG_BITS (4096) odd numbers in a one-bit
// bitmap ram; entry i stands for 2*(segment*SEG_BITS + i) + 1. Requests are
// taken one at a time and each gives exactly one result beat. An open request
// clears the bitmap with a sweep of one entry per cycle; the same sweep runs
// after reset, and no request is taken until it has finished. A cross-out
// request runs a one-bit-per-cycle remainder divider (32 steps) to find the
// first multiple in the segment, then setup steps (squaring the prime, picking
// the start), then writes one bitmap entry per cycle for each odd multiple
// from that start that falls in the segment. A fetch request reads the bitmap
// one entry per cycle from the scan position, and in segment 0 the first fetch
// returns 2. A finished result sits in an output register, and the next
// request is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module segmented_odd_prime_sieve (
  input logic    clk,
  input logic    rst,
  sops_req_if.sink   req,
  sops_rsp_if.source rsp
);
  import sops_pkg::*;

  // command and status between the sequencer and the datapath
  sops_cmd_t    cmd;
  sops_status_t status;

  // the sequencer owns both handshakes
  sops_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // request payload is captured on the accepting beat, result payload is
  // loaded into the output register when the result beat is raised
  sops_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .req_type (req.req_type),
    .segment  (req.segment),
    .prime    (req.prime),
    .value    (rsp.value),
    .found    (rsp.found)
  );

endmodule
